// ----- sv/wmv_pkg.sv -----
package wmv_pkg;

  localparam int unsigned MAX_WINDOW_SIDE = 32;
  localparam int unsigned SIDE_W          = 6;
  localparam int unsigned TARGET_W        = 2 * SIDE_W;
  localparam int unsigned MAX_PIXELS      = MAX_WINDOW_SIDE * MAX_WINDOW_SIDE;
  localparam int unsigned COUNT_W         = $clog2(MAX_PIXELS + 1);

  localparam int unsigned PIXEL_W  = 8;
  localparam int unsigned FRAC_W   = 8;
  localparam int unsigned MEAN_W   = PIXEL_W + FRAC_W;
  localparam int unsigned DIFF_W   = MEAN_W;
  localparam int unsigned TERM_W   = 2 * DIFF_W;
  localparam int unsigned SUM_W    = TERM_W + COUNT_W;
  localparam int unsigned RESULT_W = 24;

  // variance divides sum/256 by count, mean divides sum*256 by count
  localparam int unsigned DIVIDEND_W = SUM_W - FRAC_W;
  localparam int unsigned STEP_W     = $clog2(DIVIDEND_W + 1);
  localparam int unsigned WIDE_W     = SUM_W + FRAC_W;

  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int unsigned DATA_W = 32;
  localparam int unsigned ADDR_W = 3;

  localparam logic REG_WIDTH_IDX  = 1'b0;
  localparam logic REG_HEIGHT_IDX = 1'b1;

  localparam logic [SIDE_W-1:0] SIDE_RESET = SIDE_W'(3);

  typedef enum logic {
    KIND_MEAN     = 1'b0,
    KIND_VARIANCE = 1'b1
  } kind_e;

  typedef struct packed {
    logic [SUM_W-1:0]   sum;
    logic [COUNT_W-1:0] count;
    kind_e              kind;
  } job_t;

  function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] side);
    logic [SIDE_W-1:0] res;
    res = side;
    if (side == '0) begin
      res = SIDE_W'(1);
    end else if (side > SIDE_W'(MAX_WINDOW_SIDE)) begin
      res = SIDE_W'(MAX_WINDOW_SIDE);
    end
    return res;
  endfunction

endpackage

// ----- sv/wmv_front.sv -----
module wmv_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [wmv_pkg::PIXEL_W-1:0]         pixel_i,
  input  logic                                mode_i,
  input  logic [wmv_pkg::MEAN_W-1:0]          reference_mean_i,
  input  logic [wmv_pkg::SIDE_W-1:0]          window_width_i,
  input  logic [wmv_pkg::SIDE_W-1:0]          window_height_i,
  input  logic [wmv_pkg::QCNT_W-1:0]          queue_level_i,
  output logic                                push_o,
  output wmv_pkg::job_t                       job_o
);

  logic                              accept;
  logic                              first;
  logic                              last;
  wmv_pkg::kind_e                    cur_kind;
  logic [wmv_pkg::MEAN_W-1:0]        cur_mean;
  logic [wmv_pkg::MEAN_W-1:0]        scaled;
  logic [wmv_pkg::DIFF_W-1:0]        diff;
  logic [wmv_pkg::TARGET_W-1:0]      target;
  logic [wmv_pkg::COUNT_W-1:0]       count_inc;

  logic [wmv_pkg::COUNT_W-1:0]       count_q;
  wmv_pkg::kind_e                    kind_q;
  logic [wmv_pkg::MEAN_W-1:0]        mean_q;

  logic                              s1_valid_q;
  logic                              s1_first_q;
  logic                              s1_last_q;
  wmv_pkg::kind_e                    s1_kind_q;
  logic [wmv_pkg::DIFF_W-1:0]        s1_diff_q;
  logic [wmv_pkg::COUNT_W-1:0]       s1_count_q;

  logic [wmv_pkg::TERM_W-1:0]        term;
  logic [wmv_pkg::SUM_W-1:0]         sum_d;
  logic [wmv_pkg::SUM_W-1:0]         sum_q;

  // one in-flight window end may still land after the stall goes up
  assign in_stall_o = queue_level_i >= wmv_pkg::QCNT_W'(wmv_pkg::QUEUE_DEPTH - 1);
  assign accept     = in_valid_i && !in_stall_o;

  assign target    = wmv_pkg::TARGET_W'(wmv_pkg::clamp_side(window_width_i))
                   * wmv_pkg::TARGET_W'(wmv_pkg::clamp_side(window_height_i));
  assign first     = count_q == '0;
  assign count_inc = count_q + wmv_pkg::COUNT_W'(1);
  assign last      = wmv_pkg::TARGET_W'(count_inc) >= target;

  assign cur_kind = first ? wmv_pkg::kind_e'(mode_i) : kind_q;
  assign cur_mean = first ? reference_mean_i : mean_q;
  assign scaled   = {pixel_i, wmv_pkg::FRAC_W'(0)};

  always_comb begin
    if (cur_kind == wmv_pkg::KIND_VARIANCE) begin
      diff = (scaled >= cur_mean) ? (scaled - cur_mean) : (cur_mean - scaled);
    end else begin
      diff = wmv_pkg::DIFF_W'(pixel_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      kind_q     <= wmv_pkg::KIND_MEAN;
      mean_q     <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
      if (accept) begin
        count_q <= last ? '0 : count_inc;
        if (first) begin
          kind_q <= cur_kind;
          mean_q <= cur_mean;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_first_q <= first;
      s1_last_q  <= last;
      s1_kind_q  <= cur_kind;
      s1_diff_q  <= diff;
      s1_count_q <= count_inc;
    end
  end

  always_comb begin
    if (s1_kind_q == wmv_pkg::KIND_VARIANCE) begin
      term = s1_diff_q * s1_diff_q;
    end else begin
      term = wmv_pkg::TERM_W'(s1_diff_q);
    end
    sum_d = (s1_first_q ? '0 : sum_q) + wmv_pkg::SUM_W'(term);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else if (s1_valid_q) begin
      sum_q <= sum_d;
    end
  end

  assign push_o     = s1_valid_q && s1_last_q;
  assign job_o.sum   = sum_d;
  assign job_o.count = s1_count_q;
  assign job_o.kind  = s1_kind_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q < wmv_pkg::COUNT_W'(wmv_pkg::MAX_PIXELS))
    else $error("pixel count out of range");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> queue_level_i < wmv_pkg::QCNT_W'(wmv_pkg::QUEUE_DEPTH))
    else $error("window end with queue full");

endmodule

// ----- sv/wmv_queue.sv -----
module wmv_queue (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  wmv_pkg::job_t              job_i,
  input  logic                       pop_i,
  output wmv_pkg::job_t              job_o,
  output logic                       empty_o,
  output logic [wmv_pkg::QCNT_W-1:0] level_o
);

  wmv_pkg::job_t               mem_q [wmv_pkg::QUEUE_DEPTH];
  logic [wmv_pkg::QPTR_W-1:0]  wr_ptr_q;
  logic [wmv_pkg::QPTR_W-1:0]  rd_ptr_q;
  logic [wmv_pkg::QCNT_W-1:0]  level_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + wmv_pkg::QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + wmv_pkg::QPTR_W'(1);
      end
      if (push_i && !pop_i) begin
        level_q <= level_q + wmv_pkg::QCNT_W'(1);
      end else if (pop_i && !push_i) begin
        level_q <= level_q - wmv_pkg::QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  assign job_o   = mem_q[rd_ptr_q];
  assign empty_o = level_q == '0;
  assign level_o = level_q;

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> level_q != '0)
    else $error("queue pop while empty");

endmodule

// ----- sv/wmv_back.sv -----
module wmv_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  wmv_pkg::job_t                job_i,
  input  logic                         empty_i,
  output logic                         pop_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [wmv_pkg::RESULT_W-1:0] result_value_o,
  output logic                         result_kind_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_DONE
  } state_e;

  state_e                             state_q;
  logic [wmv_pkg::COUNT_W-1:0]        rem_q;
  logic [wmv_pkg::COUNT_W-1:0]        div_q;
  logic [wmv_pkg::DIVIDEND_W-1:0]     quo_q;
  logic [wmv_pkg::STEP_W-1:0]         step_q;
  wmv_pkg::kind_e                     kind_q;
  logic                               out_valid_q;
  logic [wmv_pkg::RESULT_W-1:0]       out_value_q;
  logic                               out_kind_q;

  logic [wmv_pkg::WIDE_W-1:0]         shifted;
  logic [wmv_pkg::DIVIDEND_W-1:0]     dividend;
  logic [wmv_pkg::COUNT_W:0]          trial;
  logic                               fits;
  logic [wmv_pkg::COUNT_W:0]          diff;
  logic                               slot_free;
  logic                               over;
  logic [wmv_pkg::RESULT_W-1:0]       sat_value;

  assign pop_o     = (state_q == S_IDLE) && !empty_i;
  assign slot_free = !out_valid_q || !out_stall_i;

  always_comb begin
    shifted = {job_i.sum, wmv_pkg::FRAC_W'(0)};
    if (job_i.kind == wmv_pkg::KIND_VARIANCE) begin
      dividend = job_i.sum[wmv_pkg::SUM_W-1:wmv_pkg::FRAC_W];
    end else begin
      dividend = shifted[wmv_pkg::DIVIDEND_W-1:0];
    end
  end

  // restoring division, one quotient bit per cycle
  assign trial = {rem_q, quo_q[wmv_pkg::DIVIDEND_W-1]};
  assign fits  = trial >= {1'b0, div_q};
  assign diff  = trial - {1'b0, div_q};

  assign over      = |quo_q[wmv_pkg::DIVIDEND_W-1:wmv_pkg::RESULT_W];
  assign sat_value = over ? '1 : quo_q[wmv_pkg::RESULT_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if ((state_q == S_DONE) && slot_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (!empty_i) begin
            state_q <= S_DIV;
            step_q  <= wmv_pkg::STEP_W'(wmv_pkg::DIVIDEND_W - 1);
          end
        end
        S_DIV: begin
          if (step_q == '0) begin
            state_q <= S_DONE;
          end else begin
            step_q <= step_q - wmv_pkg::STEP_W'(1);
          end
        end
        S_DONE: begin
          if (slot_free) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (!empty_i) begin
          rem_q  <= '0;
          div_q  <= job_i.count;
          quo_q  <= dividend;
          kind_q <= job_i.kind;
        end
      end
      S_DIV: begin
        rem_q <= fits ? diff[wmv_pkg::COUNT_W-1:0] : trial[wmv_pkg::COUNT_W-1:0];
        quo_q <= {quo_q[wmv_pkg::DIVIDEND_W-2:0], fits};
      end
      S_DONE: begin
        if (slot_free) begin
          out_value_q <= sat_value;
          out_kind_q  <= kind_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o    = out_valid_q;
  assign result_value_o = out_value_q;
  assign result_kind_o  = out_kind_q;

  a_rem_below_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (rem_q < div_q))
    else $error("divider remainder not below divisor");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (div_q != '0))
    else $error("zero pixel count reached divider");

endmodule

// ----- sv/window_mean_variance.sv -----
// Channel  Direction  Handshake                   Payload
// config   in/out     psel, penable, pready       paddr, pwdata, pwrite, prdata
// pixel    in         in_valid_i / in_stall_o     pixel_i, mode_i, reference_mean_i
// result   out        out_valid_o / out_stall_i   result_value_o, result_kind_o
//
// Pixels are taken one per cycle while in_stall_o is low. A window's sum is queued in the cycle after its last pixel.
// The shared divider serves both mean and variance windows and finishes one window before it
// pops the next; the job queue stalls the pixel side at three entries.
// Reset is asynchronous, active low; both side registers come out of reset at 3.
// A stalled result holds in the output register while the divider works on the next window.
module window_mean_variance (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [wmv_pkg::ADDR_W-1:0]        paddr,
  input  logic [wmv_pkg::DATA_W-1:0]        pwdata,
  output logic [wmv_pkg::DATA_W-1:0]        prdata,
  output logic                              pready,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [wmv_pkg::PIXEL_W-1:0]       pixel_i,
  input  logic                              mode_i,
  input  logic [wmv_pkg::MEAN_W-1:0]        reference_mean_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [wmv_pkg::RESULT_W-1:0]      result_value_o,
  output logic                              result_kind_o
);

  logic [wmv_pkg::SIDE_W-1:0]  width_q;
  logic [wmv_pkg::SIDE_W-1:0]  height_q;
  logic                        cfg_write;
  logic                        reg_idx;

  logic                        push;
  logic                        pop;
  logic                        empty;
  logic [wmv_pkg::QCNT_W-1:0]  level;
  wmv_pkg::job_t               push_job;
  wmv_pkg::job_t               head_job;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_idx   = paddr[wmv_pkg::ADDR_W-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= wmv_pkg::SIDE_RESET;
      height_q <= wmv_pkg::SIDE_RESET;
    end else if (cfg_write) begin
      if (reg_idx == wmv_pkg::REG_HEIGHT_IDX) begin
        height_q <= pwdata[wmv_pkg::SIDE_W-1:0];
      end else begin
        width_q <= pwdata[wmv_pkg::SIDE_W-1:0];
      end
    end
  end

  assign prdata = (reg_idx == wmv_pkg::REG_HEIGHT_IDX) ? wmv_pkg::DATA_W'(height_q)
                                                       : wmv_pkg::DATA_W'(width_q);

  wmv_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .pixel_i          (pixel_i),
    .mode_i           (mode_i),
    .reference_mean_i (reference_mean_i),
    .window_width_i   (width_q),
    .window_height_i  (height_q),
    .queue_level_i    (level),
    .push_o           (push),
    .job_o            (push_job)
  );

  wmv_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .pop_i   (pop),
    .job_o   (head_job),
    .empty_o (empty),
    .level_o (level)
  );

  wmv_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .job_i          (head_job),
    .empty_i        (empty),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .result_value_o (result_value_o),
    .result_kind_o  (result_kind_o)
  );

endmodule

// ----- dv/tb_window_mean_variance.sv -----
module tb_window_mean_variance;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [wmv_pkg::RESULT_W-1:0] value;
    wmv_pkg::kind_e               kind;
  } window_result_t;

  logic                         clk_i            = 1'b0;
  logic                         rst_ni           = 1'b0;
  logic                         psel             = 1'b0;
  logic                         penable          = 1'b0;
  logic                         pwrite           = 1'b0;
  logic [wmv_pkg::ADDR_W-1:0]   paddr            = '0;
  logic [wmv_pkg::DATA_W-1:0]   pwdata           = '0;
  logic [wmv_pkg::DATA_W-1:0]   prdata;
  logic                         pready;
  logic                         in_valid_i       = 1'b0;
  logic                         in_stall_o;
  logic [wmv_pkg::PIXEL_W-1:0]  pixel_i          = '0;
  logic                         mode_i           = 1'b0;
  logic [wmv_pkg::MEAN_W-1:0]   reference_mean_i = '0;
  logic                         out_valid_o;
  logic                         out_stall_i      = 1'b0;
  logic [wmv_pkg::RESULT_W-1:0] result_value_o;
  logic                         result_kind_o;

  // predictor state
  logic [wmv_pkg::SIDE_W-1:0]   width_reg    = wmv_pkg::SIDE_RESET;
  logic [wmv_pkg::SIDE_W-1:0]   height_reg   = wmv_pkg::SIDE_RESET;
  int unsigned                  pixels_taken = 0;
  logic [63:0]                  window_acc   = '0;
  wmv_pkg::kind_e               window_kind  = wmv_pkg::KIND_MEAN;
  logic [wmv_pkg::MEAN_W-1:0]   window_mean  = '0;
  window_result_t               window_results_q[$];

  int unsigned                  mismatch_cnt   = 0;
  int unsigned                  send_idle_pct  = 0;
  int unsigned                  recv_stall_pct = 0;
  int unsigned                  items_sent     = 0;

  window_mean_variance dut (.*);

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

  function automatic int unsigned side_len(input logic [wmv_pkg::SIDE_W-1:0] side);
    if (side == '0) return 1;
    if (side > wmv_pkg::MAX_WINDOW_SIDE) return wmv_pkg::MAX_WINDOW_SIDE;
    return 32'(side);
  endfunction

  function automatic int unsigned window_size();
    return side_len(width_reg) * side_len(height_reg);
  endfunction

  function automatic logic [wmv_pkg::PIXEL_W-1:0] rand_pixel();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return wmv_pkg::PIXEL_W'($urandom());
    endcase
  endfunction

  function automatic logic [wmv_pkg::MEAN_W-1:0] rand_mean();
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      default: return wmv_pkg::MEAN_W'($urandom());
    endcase
  endfunction

  function automatic logic [wmv_pkg::SIDE_W-1:0] rand_side();
    case ($urandom_range(9))
      0: return '0;
      1: return wmv_pkg::SIDE_W'($urandom_range(5, 8));
      default: return wmv_pkg::SIDE_W'($urandom_range(1, 4));
    endcase
  endfunction

  function automatic void set_idling(input int unsigned send_pct, input int unsigned recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endfunction

  function automatic void flag_mismatch(input string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) $display("[%0t] %s", $time, msg);
  endfunction

  // window accumulation, result pushed when the count reaches the current size
  function automatic void predict_pixel(input logic [wmv_pkg::PIXEL_W-1:0] pix,
                                        input wmv_pkg::kind_e kind,
                                        input logic [wmv_pkg::MEAN_W-1:0] mean);
    logic [wmv_pkg::MEAN_W-1:0] scaled;
    logic [wmv_pkg::MEAN_W-1:0] diff;
    logic [63:0]                quot;
    window_result_t             res;
    if (pixels_taken == 0) begin
      window_kind = kind;
      window_mean = mean;
      window_acc  = '0;
    end
    if (window_kind == wmv_pkg::KIND_MEAN) begin
      window_acc += 64'(pix);
    end else begin
      scaled = {pix, wmv_pkg::FRAC_W'(0)};
      diff = (scaled >= window_mean) ? scaled - window_mean : window_mean - scaled;
      window_acc += 64'(diff) * 64'(diff);
    end
    pixels_taken++;
    if (pixels_taken >= window_size()) begin
      if (window_kind == wmv_pkg::KIND_MEAN) begin
        quot = (window_acc << wmv_pkg::FRAC_W) / 64'(pixels_taken);
      end else begin
        quot = window_acc / (64'(pixels_taken) << wmv_pkg::FRAC_W);
      end
      if (quot > 64'hFF_FFFF) quot = 64'hFF_FFFF;
      res.value = quot[wmv_pkg::RESULT_W-1:0];
      res.kind  = window_kind;
      window_results_q.push_back(res);
      pixels_taken = 0;
      window_acc   = '0;
    end
  endfunction

  // called at a rising edge, returns at the edge where the request is taken
  task automatic send_pixel(input logic [wmv_pkg::PIXEL_W-1:0] pix,
                            input wmv_pkg::kind_e kind,
                            input logic [wmv_pkg::MEAN_W-1:0] mean);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    pixel_i          <= pix;
    mode_i           <= kind;
    reference_mean_i <= mean;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
    predict_pixel(pix, kind, mean);
  endtask

  // rest of the current window; mode and mean on later pixels are random and ignored
  task automatic send_window(input wmv_pkg::kind_e kind,
                             input logic [wmv_pkg::MEAN_W-1:0] mean);
    int unsigned remaining;
    remaining = (window_size() > pixels_taken) ? window_size() - pixels_taken : 1;
    for (int unsigned i = 0; i < remaining; i++) begin
      if (i == 0) send_pixel(rand_pixel(), kind, mean);
      else send_pixel(rand_pixel(), wmv_pkg::kind_e'($urandom_range(1)), rand_mean());
    end
  endtask

  task automatic write_side(input logic idx, input logic [wmv_pkg::SIDE_W-1:0] side);
    logic [wmv_pkg::DATA_W-1:0] word;
    word = $urandom();
    word[wmv_pkg::SIDE_W-1:0] = side;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= wmv_pkg::ADDR_W'({idx, 2'b00});
    pwdata  <= word;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx == wmv_pkg::REG_WIDTH_IDX) width_reg = side;
    else height_reg = side;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_window(input logic [wmv_pkg::SIDE_W-1:0] w,
                            input logic [wmv_pkg::SIDE_W-1:0] h);
    write_side(wmv_pkg::REG_WIDTH_IDX, w);
    write_side(wmv_pkg::REG_HEIGHT_IDX, h);
  endtask

  // a partial window may still sit in the accumulator pipeline, so pad after the drain
  task automatic wait_quiet();
    in_valid_i <= 1'b0;
    while (window_results_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic test_directed_cases();
    set_idling(0, 0);
    // reset size 3x3, alternating extremes, mode toggling on later pixels
    for (int i = 0; i < 9; i++) begin
      send_pixel((i % 2) ? 8'd0 : 8'd255,
                 (i % 2) ? wmv_pkg::KIND_VARIANCE : wmv_pkg::KIND_MEAN,
                 (i % 2) ? 16'hFFFF : 16'h0000);
    end
    wait_quiet();
    // zero width acts as one: single-pixel windows
    set_window('0, wmv_pkg::SIDE_W'(1));
    send_pixel(8'd255, wmv_pkg::KIND_MEAN, 16'h0000);
    send_pixel(8'd0, wmv_pkg::KIND_MEAN, 16'hFFFF);
    send_pixel(8'd0, wmv_pkg::KIND_VARIANCE, 16'hFFFF);
    send_pixel(8'd255, wmv_pkg::KIND_VARIANCE, 16'h0000);
    send_pixel(8'd128, wmv_pkg::KIND_VARIANCE, 16'h8000);
    send_pixel(8'd1, wmv_pkg::KIND_VARIANCE, 16'h0001);
    wait_quiet();
    // shrink the window after three of four pixels; next pixel closes it
    set_window(wmv_pkg::SIDE_W'(2), wmv_pkg::SIDE_W'(2));
    send_pixel(8'd200, wmv_pkg::KIND_VARIANCE, 16'h1234);
    send_pixel(8'd17, wmv_pkg::KIND_MEAN, 16'hFFFF);
    send_pixel(8'd99, wmv_pkg::KIND_MEAN, 16'h0000);
    wait_quiet();
    write_side(wmv_pkg::REG_WIDTH_IDX, wmv_pkg::SIDE_W'(1));
    send_pixel(8'd3, wmv_pkg::KIND_MEAN, 16'h0000);
    wait_quiet();
  endtask

  task automatic test_side_extremes();
    set_idling(16, 16);
    set_window('0, '0);
    send_window(wmv_pkg::KIND_MEAN, rand_mean());
    send_window(wmv_pkg::KIND_VARIANCE, rand_mean());
    wait_quiet();
    set_window('1, wmv_pkg::SIDE_W'(1));
    send_window(wmv_pkg::KIND_VARIANCE, rand_mean());
    wait_quiet();
    set_window(wmv_pkg::SIDE_W'(1), wmv_pkg::SIDE_W'(40));
    send_window(wmv_pkg::KIND_MEAN, rand_mean());
    wait_quiet();
    set_window(wmv_pkg::SIDE_W'(33), wmv_pkg::SIDE_W'(1));
    send_window(wmv_pkg::KIND_MEAN, rand_mean());
    wait_quiet();
    // largest window, variance against the top of the mean range
    set_window(wmv_pkg::SIDE_W'(wmv_pkg::MAX_WINDOW_SIDE),
               wmv_pkg::SIDE_W'(wmv_pkg::MAX_WINDOW_SIDE));
    send_window(wmv_pkg::KIND_VARIANCE, 16'hFFFF);
    wait_quiet();
  endtask

  task automatic test_random_windows();
    int unsigned phase;
    int unsigned n_win;
    int unsigned part;
    logic [wmv_pkg::SIDE_W-1:0] w;
    logic [wmv_pkg::SIDE_W-1:0] h;
    phase = 0;
    while (phase < 4 || items_sent < 1200) begin
      case (phase % 4)
        0: set_idling(0, 0);
        1: set_idling(65, 0);
        2: set_idling(0, 65);
        default: set_idling(16, 16);
      endcase
      w = rand_side();
      h = rand_side();
      if ($urandom_range(7) == 0) begin
        w = wmv_pkg::SIDE_W'($urandom_range(33, 63));
        h = $urandom_range(1) ? '0 : wmv_pkg::SIDE_W'(1);
      end
      set_window(w, h);
      n_win = $urandom_range(3, 12);
      repeat (n_win) begin
        send_window(wmv_pkg::kind_e'($urandom_range(1)), rand_mean());
      end
      // leave a partial window so the next size change lands mid-window
      if ($urandom_range(2) == 0 && window_size() > 1) begin
        part = $urandom_range(1, window_size() - 1);
        for (int unsigned i = 0; i < part; i++) begin
          send_pixel(rand_pixel(), wmv_pkg::kind_e'($urandom_range(1)), rand_mean());
        end
      end
      wait_quiet();
      phase++;
    end
  endtask

  always @(posedge clk_i) begin
    window_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (window_results_q.size() == 0) begin
        flag_mismatch($sformatf("result with no window pending: value %0d kind %0d",
                                result_value_o, result_kind_o));
      end else begin
        want = window_results_q.pop_front();
        if (result_value_o !== want.value)
          flag_mismatch($sformatf("result_value: expected %0d, got %0d",
                                  want.value, result_value_o));
        if (result_kind_o !== want.kind)
          flag_mismatch($sformatf("result_kind: expected %0d, got %0d",
                                  want.kind, result_kind_o));
      end
    end
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (5) @(posedge clk_i);
    test_directed_cases();
    test_side_extremes();
    test_random_windows();
    wait_quiet();
    if (window_results_q.size() != 0) begin
      flag_mismatch($sformatf("%0d results never arrived", window_results_q.size()));
    end
    if (mismatch_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
